[hdl/bbpa_pkg.sv]
// types and codes for the binary buddy page allocator
`timescale 1ns / 1ps
`default_nettype none
package bbpa_pkg;

    localparam int BYTES_W = 25;
    localparam int PAGE_W  = 12;
    localparam int CFG_W   = 13;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOBLOCK = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [BYTES_W-1:0] request_bytes;
        logic [PAGE_W-1:0]  freed_page;
    } bbpa_req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] granted_page;
        logic [1:0]        status;
    } bbpa_rsp_t;

endpackage
`default_nettype wire

[hdl/binary_buddy_page_allocator.sv]
// binary buddy page allocator: sequencer around one free map memory
//
//   channel   signals                      transaction
//   request   start, busy, req             start high while busy low
//   result    done, rsp                    done high for one cycle
//   config    cfg_valid, cfg_ready, data   valid and ready high
//
// all work goes through one free map port, one bit per access (read data is registered).
// init: a clear of all 2^ORDER_COUNT-1 map bits, then a seed pass from the top order down.
// alloc: map bits are scanned (read, then check) from the request order upward, then split.
// free: map bits covering the block are checked at each order, then buddies are merged.
// after reset a clearing pass over the whole map keeps busy high.
// results cannot be stalled; config is always ready.
`timescale 1ns / 1ps
`default_nettype none
module binary_buddy_page_allocator #(
    parameter int PAGE_BYTES_LOG2 = 12,
    parameter int ORDER_COUNT     = 13
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire bbpa_pkg::bbpa_req_t            req,
    output logic                                done,
    output bbpa_pkg::bbpa_rsp_t                 rsp,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bbpa_pkg::CFG_W-1:0]     cfg_data
);
    import bbpa_pkg::*;

    localparam int AW    = ORDER_COUNT;
    localparam int KW    = $clog2(ORDER_COUNT + 1);
    localparam int DEPTH = (1 << ORDER_COUNT) - 1;
    localparam int POOL  = 1 << (ORDER_COUNT - 1);

    localparam logic [AW-1:0] ONE_A  = AW'(1);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
    localparam logic [AW-1:0] POOL_A = AW'(POOL);
    localparam logic [KW-1:0] TOP_K  = KW'(ORDER_COUNT - 1);
    localparam logic [KW-1:0] OC_K   = KW'(ORDER_COUNT);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_SEED = 4'd2;
    localparam logic [3:0] S_SRD  = 4'd3;
    localparam logic [3:0] S_SCK  = 4'd4;
    localparam logic [3:0] S_SPL  = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FCK  = 4'd7;
    localparam logic [3:0] S_MRD  = 4'd8;
    localparam logic [3:0] S_MCK  = 4'd9;
    localparam logic [3:0] S_MSET = 4'd10;

    function automatic logic [AW-1:0] map_base(input logic [KW-1:0] k);
        logic [AW:0] full;
        full = {1'b1, {AW{1'b0}}};
        return AW'(full - (full >> k));
    endfunction

    function automatic logic [KW-1:0] size_order(input logic [BYTES_W-1:0] bytes);
        logic [KW-1:0] k;
        k = '0;
        for (int n = 0; n < ORDER_COUNT; n++)
        begin
            if ((PAGE_BYTES_LOG2 + n < BYTES_W) &&
                (bytes > (BYTES_W'(1) << (PAGE_BYTES_LOG2 + n))))
            begin
                k = KW'(n + 1);
            end
        end
        return k;
    endfunction

    // last index to check at order j for a block of order k at page
    function automatic logic [AW-1:0] chk_last(input logic [AW-1:0] page,
                                               input logic [KW-1:0] j,
                                               input logic [KW-1:0] k);
        logic [AW-1:0] span;
        span = (j < k) ? (ONE_A << (k - j)) : ONE_A;
        return (page >> j) + span - ONE_A;
    endfunction

    logic [3:0]       state_reg, state_next;
    logic             init_reg, init_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [KW-1:0]    j_reg, j_next;
    logic [KW-1:0]    want_reg, want_next;
    logic [AW-1:0]    i_reg, i_next;
    logic [AW-1:0]    last_reg, last_next;
    logic [AW-1:0]    page_reg, page_next;
    logic [AW-1:0]    pages_reg, pages_next;
    logic [CFG_W-1:0] managed_reg;
    logic             done_reg, done_next;
    bbpa_rsp_t        rsp_reg, rsp_next;

    logic             free_map_reg [DEPTH];
    logic             rd_reg;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;
    logic             mem_wd;

    logic [KW-1:0]    jm;
    logic [KW-1:0]    jn;
    logic [KW-1:0]    req_k;
    logic [AW-1:0]    req_page;
    logic             bad_free;

    assign jm        = j_reg - KW'(1);
    assign jn        = j_reg + KW'(1);
    assign req_k     = size_order(req.request_bytes);
    assign req_page  = AW'(req.freed_page);
    assign bad_free  = (req_k >= OC_K) ||
                       ((req.freed_page & ~({PAGE_W{1'b1}} << req_k)) != '0) ||
                       (32'(req.freed_page) >= POOL);

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (state_reg)
            S_CLR:          mem_addr = clr_reg;
            S_SEED:         mem_addr = map_base(j_reg) + (page_reg >> j_reg);
            S_SPL:          mem_addr = map_base(jm) + (page_reg >> jm);
            S_MRD, S_MCK:   mem_addr = map_base(j_reg) + (i_reg ^ ONE_A);
            default:        mem_addr = map_base(j_reg) + i_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        clr_next   = clr_reg;
        j_next     = j_reg;
        want_next  = want_reg;
        i_next     = i_reg;
        last_next  = last_reg;
        page_next  = page_reg;
        pages_next = pages_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_wd     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    want_next = req_k;
                    page_next = req_page;
                    rsp_next  = '{granted_page: '0, status: ST_OK};
                    case (req.operation)
                        OP_INIT:
                        begin
                            init_next  = 1'b1;
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        OP_ALLOC:
                        begin
                            if (req_k >= OC_K)
                            begin
                                rsp_next.status = ST_NOBLOCK;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                j_next     = req_k;
                                i_next     = '0;
                                state_next = S_SRD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (bad_free)
                            begin
                                rsp_next.status = ST_BADFREE;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                j_next     = '0;
                                i_next     = req_page;
                                last_next  = chk_last(req_page, '0, req_k);
                                state_next = S_FRD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + ONE_A;
                if (clr_reg == LAST_A)
                begin
                    if (init_reg)
                    begin
                        j_next     = TOP_K;
                        page_next  = '0;
                        pages_next = (32'(managed_reg) > POOL) ? POOL_A : AW'(managed_reg);
                        state_next = S_SEED;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SEED:
            begin
                if (pages_reg[j_reg])
                begin
                    mem_we    = 1'b1;
                    mem_wd    = 1'b1;
                    page_next = page_reg + (ONE_A << j_reg);
                end
                if (j_reg == '0)
                begin
                    init_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next = jm;
                end
            end
            S_SRD:
            begin
                state_next = S_SCK;
            end
            S_SCK:
            begin
                if (rd_reg)
                begin
                    mem_we    = 1'b1;
                    page_next = i_reg << j_reg;
                    if (j_reg == want_reg)
                    begin
                        rsp_next.granted_page = PAGE_W'(i_reg << j_reg);
                        done_next             = 1'b1;
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SPL;
                    end
                end
                else if (i_reg == ((POOL_A >> j_reg) - ONE_A))
                begin
                    if (j_reg == TOP_K)
                    begin
                        rsp_next.status = ST_NOBLOCK;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        j_next     = jn;
                        i_next     = '0;
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    i_next     = i_reg + ONE_A;
                    state_next = S_SRD;
                end
            end
            S_SPL:
            begin
                mem_we    = 1'b1;
                mem_wd    = 1'b1;
                page_next = page_reg + (ONE_A << jm);
                j_next    = jm;
                if (jm == want_reg)
                begin
                    rsp_next.granted_page = PAGE_W'(page_reg + (ONE_A << jm));
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_FRD:
            begin
                state_next = S_FCK;
            end
            S_FCK:
            begin
                if (rd_reg)
                begin
                    rsp_next.status = ST_BADFREE;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (i_reg == last_reg)
                begin
                    if (j_reg == TOP_K)
                    begin
                        j_next     = want_reg;
                        i_next     = page_reg >> want_reg;
                        state_next = S_MRD;
                    end
                    else
                    begin
                        j_next     = jn;
                        i_next     = page_reg >> jn;
                        last_next  = chk_last(page_reg, jn, want_reg);
                        state_next = S_FRD;
                    end
                end
                else
                begin
                    i_next     = i_reg + ONE_A;
                    state_next = S_FRD;
                end
            end
            S_MRD:
            begin
                state_next = (jn < OC_K) ? S_MCK : S_MSET;
            end
            S_MCK:
            begin
                if (rd_reg)
                begin
                    mem_we     = 1'b1;
                    i_next     = i_reg >> 1;
                    j_next     = jn;
                    state_next = S_MRD;
                end
                else
                begin
                    state_next = S_MSET;
                end
            end
            S_MSET:
            begin
                mem_we     = 1'b1;
                mem_wd     = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            free_map_reg[mem_addr] <= mem_wd;
        end
        rd_reg <= free_map_reg[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        want_reg  <= want_next;
        i_reg     <= i_next;
        last_reg  <= last_next;
        page_reg  <= page_next;
        pages_reg <= pages_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            init_reg    <= 1'b0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
            managed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                managed_reg <= cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

[tb/bbpa_checker.sv]
// checker for the binary buddy page allocator: predicts each result and compares it
`timescale 1ns / 1ps
`default_nettype none
module bbpa_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire bbpa_pkg::bbpa_req_t        req,
    input  wire logic                       done,
    input  wire bbpa_pkg::bbpa_rsp_t        rsp,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [bbpa_pkg::CFG_W-1:0] cfg_data,
    output int                              failures
);
    import bbpa_pkg::*;

    localparam int ORDERS    = 13;
    localparam int PAGE_LOG2 = 12;
    localparam int POOL      = 1 << (ORDERS - 1);
    localparam int DEPTH     = (1 << ORDERS) - 1;

    bit               free_bits [0:DEPTH-1];
    logic [CFG_W-1:0] seed_pages;
    bbpa_rsp_t        expected_rsp_q [$];
    int               mismatches;
    int               outstanding;

    assign failures = mismatches + outstanding;

    function automatic int map_addr(int k, int idx);
        return (1 << ORDERS) - (1 << (ORDERS - k)) + idx;
    endfunction

    function automatic bit is_free(int k, int idx);
        int a;
        a = map_addr(k, idx);
        return (a < DEPTH) ? free_bits[a] : 1'b0;
    endfunction

    function automatic void mark(int k, int idx, bit v);
        int a;
        a = map_addr(k, idx);
        if (a < DEPTH)
            free_bits[a] = v;
    endfunction

    function automatic int bytes_to_order(logic [BYTES_W-1:0] bytes);
        int k;
        k = 0;
        while (k < ORDERS && 64'(bytes) > (64'd1 << (PAGE_LOG2 + k)))
            k++;
        return k;
    endfunction

    function automatic void seed_pool();
        int left;
        int page;
        left = (int'(seed_pages) > POOL) ? POOL : int'(seed_pages);
        page = 0;
        foreach (free_bits[a])
            free_bits[a] = 1'b0;
        for (int k = ORDERS - 1; k >= 0; k--)
            while (left >= (1 << k))
            begin
                mark(k, page >> k, 1'b1);
                page += 1 << k;
                left -= 1 << k;
            end
    endfunction

    function automatic bbpa_rsp_t grant_block(logic [BYTES_W-1:0] bytes);
        bbpa_rsp_t r;
        int want;
        int j;
        int found;
        int page;
        bit hit;
        r = '0;
        r.status = ST_NOBLOCK;
        want = bytes_to_order(bytes);
        hit = 1'b0;
        found = 0;
        if (want >= ORDERS)
            return r;
        for (j = want; j < ORDERS; j++)
        begin
            for (int i = 0; i < (POOL >> j); i++)
                if (is_free(j, i))
                begin
                    found = i;
                    hit = 1'b1;
                    break;
                end
            if (hit)
                break;
        end
        if (!hit)
            return r;
        mark(j, found, 1'b0);
        page = found << j;
        while (j > want)
        begin
            j--;
            mark(j, page >> j, 1'b1);
            page += 1 << j;
        end
        r.status = ST_OK;
        r.granted_page = page[PAGE_W-1:0];
        return r;
    endfunction

    function automatic logic [1:0] release_block(logic [BYTES_W-1:0] bytes,
                                                 logic [PAGE_W-1:0] fpage);
        int k;
        int page;
        int idx;
        k = bytes_to_order(bytes);
        page = int'(fpage);
        if (k >= ORDERS)
            return ST_BADFREE;
        if ((page & ((1 << k) - 1)) != 0 || page >= POOL)
            return ST_BADFREE;
        for (int j = k; j < ORDERS; j++)
            if (is_free(j, page >> j))
                return ST_BADFREE;
        for (int j = 0; j < k; j++)
            for (int i = page >> j; i < (page >> j) + (1 << (k - j)); i++)
                if (is_free(j, i))
                    return ST_BADFREE;
        idx = page >> k;
        while (k + 1 < ORDERS && is_free(k, idx ^ 1))
        begin
            mark(k, idx ^ 1, 1'b0);
            idx >>= 1;
            k++;
        end
        mark(k, idx, 1'b1);
        return ST_OK;
    endfunction

    function automatic bbpa_rsp_t predict(bbpa_req_t r);
        bbpa_rsp_t e;
        e = '0;
        case (r.operation)
            OP_INIT:  seed_pool();
            OP_ALLOC: e = grant_block(r.request_bytes);
            OP_FREE:  e.status = release_block(r.request_bytes, r.freed_page);
            default:  ;
        endcase
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bbpa_rsp_t e;
        if (!rst_n)
        begin
            foreach (free_bits[a])
                free_bits[a] = 1'b0;
            seed_pages = '0;
            expected_rsp_q.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seed_pages = cfg_data;
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("result with no transaction pending: page %0d status %0d",
                           rsp.granted_page, rsp.status);
                    mismatches++;
                end
                else
                begin
                    e = expected_rsp_q.pop_front();
                    if (rsp.granted_page !== e.granted_page)
                    begin
                        $error("granted_page expected %0d actual %0d",
                               e.granted_page, rsp.granted_page);
                        mismatches++;
                    end
                    if (rsp.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, rsp.status);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_rsp_q.push_back(predict(req));
            outstanding = expected_rsp_q.size();
        end
    end

endmodule
`default_nettype wire

[tb/tb_binary_buddy_page_allocator.sv]
// testbench top for the binary buddy page allocator: stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_binary_buddy_page_allocator;
    import bbpa_pkg::*;

    localparam int WATCHDOG = 200000;

    typedef struct {
        logic [PAGE_W-1:0]  page;
        logic [BYTES_W-1:0] bytes;
    } live_block_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    bbpa_req_t        req;
    logic             done;
    bbpa_rsp_t        rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    int               failures;
    int               idle_cycles;

    bbpa_req_t   issued_q [$];
    live_block_t live_q [$];
    live_block_t freed_q [$];

    binary_buddy_page_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bbpa_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .failures  (failures)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // track grants so that frees can name live blocks
    always @(posedge clk)
    begin
        bbpa_req_t r;
        if (rst_n && done && issued_q.size() > 0)
        begin
            r = issued_q.pop_front();
            if (r.operation == OP_ALLOC && rsp.status == ST_OK)
                live_q.push_back('{rsp.granted_page, r.request_bytes});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("binary_buddy_page_allocator test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [BYTES_W-1:0] bytes_of_order(int k);
        if (k == 0)
            return BYTES_W'($urandom_range(0, 4096));
        if (k >= 13)
            return BYTES_W'($urandom_range((1 << 24) + 1, (1 << 25) - 1));
        return BYTES_W'($urandom_range((1 << (11 + k)) + 1, 1 << (12 + k)));
    endfunction

    function automatic logic [BYTES_W-1:0] random_bytes();
        if ($urandom_range(0, 15) == 0)
            return bytes_of_order($urandom_range(0, 13));
        return bytes_of_order($urandom_range(0, 4));
    endfunction

    function automatic logic [CFG_W-1:0] seed_pick();
        case ($urandom_range(0, 3))
            0:       return CFG_W'($urandom_range(1, 64));
            1:       return CFG_W'($urandom_range(0, 4096));
            2:       return CFG_W'(4096);
            default: return CFG_W'($urandom());
        endcase
    endfunction

    task automatic send(logic [1:0] op, logic [BYTES_W-1:0] bytes, logic [PAGE_W-1:0] page);
        int gap;
        bbpa_req_t r;
        gap = pick_gap();
        r.operation = op;
        r.request_bytes = bytes;
        r.freed_page = page;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        issued_q.push_back(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (issued_q.size() > 0 || busy);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_pages(logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic reseed(logic [CFG_W-1:0] v);
        drain();
        write_pages(v);
        live_q.delete();
        freed_q.delete();
        send(OP_INIT, BYTES_W'($urandom()), PAGE_W'($urandom()));
    endtask

    task automatic free_live(bit keep_copy);
        int i;
        live_block_t b;
        i = $urandom_range(0, live_q.size() - 1);
        b = live_q[i];
        live_q.delete(i);
        if (keep_copy)
            freed_q.push_back(b);
        send(OP_FREE, b.bytes, b.page);
    endtask

    task automatic random_phase(int count);
        int p;
        live_block_t b;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 50)
                send(OP_ALLOC, random_bytes(), PAGE_W'($urandom()));
            else if (p < 85 && live_q.size() > 0)
                free_live(1'b1);
            else if (p < 90 && freed_q.size() > 0)
            begin
                b = freed_q[$urandom_range(0, freed_q.size() - 1)];
                send(OP_FREE, b.bytes, b.page);
            end
            else if (p < 96)
                send(OP_FREE, BYTES_W'($urandom()), PAGE_W'($urandom()));
            else if (p < 98)
                send(OP_NONE, BYTES_W'($urandom()), PAGE_W'($urandom()));
            else
                reseed(seed_pick());
            if (freed_q.size() > 32)
                freed_q.delete(0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty pool, then a pool bigger than the map allows
        send(OP_ALLOC, '0, '0);
        send(OP_FREE, BYTES_W'(4096), '0);
        send(OP_FREE, BYTES_W'(4096), '0);
        reseed('0);
        send(OP_ALLOC, BYTES_W'(1), '0);
        reseed('1);
        send(OP_ALLOC, 25'h1FFFFFF, '0);
        send(OP_ALLOC, BYTES_W'(1 << 24), '0);
        send(OP_ALLOC, '0, '0);
        send(OP_FREE, BYTES_W'(1 << 24), '0);
        send(OP_FREE, BYTES_W'(1 << 24), '0);
        send(OP_ALLOC, BYTES_W'(4097), '0);
        send(OP_ALLOC, BYTES_W'(4096), '0);
        send(OP_FREE, BYTES_W'(8192), 12'd1);
        send(OP_FREE, 25'h1FFFFFF, '0);
        send(OP_FREE, '0, 12'hFFF);
        send(OP_NONE, 25'h1FFFFFF, 12'hFFF);
        reseed(13'd4096);
        send(OP_ALLOC, BYTES_W'(1 << 24), '0);
        send(OP_ALLOC, '0, '0);
        send(OP_FREE, '0, 12'hFFF);
        reseed(13'd4095);
        send(OP_ALLOC, BYTES_W'(1 << 23), '0);

        reseed(13'd1);
        random_phase(60);
        reseed(13'd37);
        random_phase(160);
        reseed(13'd4096);
        random_phase(200);
        reseed('1);
        random_phase(160);
        reseed(seed_pick());
        random_phase(200);

        drain();
        if (failures == 0)
            $display("binary_buddy_page_allocator test passed");
        else
            $display("binary_buddy_page_allocator test failed");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
hdl/bbpa_pkg.sv
hdl/binary_buddy_page_allocator.sv
tb/bbpa_checker.sv
tb/tb_binary_buddy_page_allocator.sv
